FILE: src/mcn_pkg.sv
// mcn_pkg: shared types and constants of the margin constraint node block
// no dependencies
`timescale 1ns / 1ps

package mcn_pkg;

   localparam int MAX_ROWS = 32;
   localparam int MAX_COLS = 64;
   localparam int ROW_AW   = $clog2(MAX_ROWS);
   localparam int COL_AW   = $clog2(MAX_COLS);

   // command codes
   localparam logic CMD_COLUMN = 1'b0;
   localparam logic CMD_ROW    = 1'b1;

   // register indexes
   localparam logic [1:0] CSR_ROW_COUNT    = 2'd0;
   localparam logic [1:0] CSR_COLUMN_COUNT = 2'd1;

   typedef struct packed {
      logic       command;
      logic [6:0] margin_value;
   } mcn_req_type;

   typedef struct packed {
      logic [4:0]  node_row;
      logic [11:0] node_excess;
      logic        no_nodes;
      logic        last_node;
   } mcn_rsp_type;

   // column scan control and result
   typedef struct packed {
      logic       start;
      logic [4:0] row;
      logic [6:0] cols;
   } mcn_scan_req_type;

   typedef struct packed {
      logic       done;
      logic [6:0] count;
   } mcn_scan_rsp_type;

endpackage

FILE: src/margin_constraint_nodes.sv
// margin_constraint_nodes: load sequencer, row memory and node stack
// after the last row sum loads, one column scan runs per row, with stack pops
// per kept node; then the nodes are emitted one by one, each held until taken
// throughput: one load per cycle while in the load state; the column scan sets the compute time
// reset: synchronous active high, counts back to 32 rows and 64 columns
// depends on mcn_pkg and mcn_col_scan
`timescale 1ns / 1ps

module margin_constraint_nodes
   import mcn_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  mcn_req_type req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output mcn_rsp_type rsp_data,
   input  logic        csr_write_en,
   input  logic [1:0]  csr_index,
   input  logic [6:0]  csr_wdata
);

   typedef enum logic [3:0] {
      ST_LOAD, ST_SCAN_START, ST_SCAN_WAIT, ST_EVAL, ST_POP, ST_POP_RD, ST_POP_LD,
      ST_NEXT, ST_OUT_RD, ST_OUT_LD, ST_OUT_HOLD
   } state_type;

   typedef struct packed {
      logic [4:0]  row;
      logic [11:0] ex;
   } node_type;

   state_type        state_ff;
   logic [5:0]       row_count_ff;
   logic [6:0]       column_count_ff;
   logic [6:0]       load_index_ff;
   logic [5:0]       rows_eff;
   logic [6:0]       cols_eff;
   logic [6:0]       row_pos;
   logic             req_take;

   logic [6:0]       row_mem [MAX_ROWS];
   logic [6:0]       row_q_ff;
   logic             row_wr;

   node_type         node_mem [MAX_ROWS];
   node_type         node_q_ff;
   logic [ROW_AW-1:0] node_raddr_ff;
   logic             node_wr;

   logic [4:0]       j_ff;
   logic [11:0]      sum_r_ff;
   logic [11:0]      sum_c_ff;
   logic [11:0]      ex;
   logic             first_any_ff;
   logic [11:0]      last_ex_ff;
   node_type         new_ff;
   node_type         top_ff;
   logic [5:0]       depth_ff;
   logic [4:0]       k_ff;
   logic signed [13:0] top_key;
   logic signed [13:0] new_key;
   logic             do_pop;

   mcn_rsp_type      rsp_ff;
   logic             rsp_valid_ff;

   mcn_scan_req_type scan_req;
   mcn_scan_rsp_type scan_rsp;

   // clamped counts
   always_comb begin
      if (row_count_ff == '0) begin
         rows_eff = 6'd1;
      end else if (row_count_ff > 6'(MAX_ROWS)) begin
         rows_eff = 6'(MAX_ROWS);
      end else begin
         rows_eff = row_count_ff;
      end
      if (column_count_ff == '0) begin
         cols_eff = 7'd1;
      end else if (column_count_ff > 7'(MAX_COLS)) begin
         cols_eff = 7'(MAX_COLS);
      end else begin
         cols_eff = column_count_ff;
      end
   end

   assign req_stall = (state_ff != ST_LOAD);
   assign req_take  = req_valid && !req_stall;
   assign row_pos   = load_index_ff - cols_eff;
   assign row_wr    = req_take && (load_index_ff >= cols_eff)
                      && (req_data.command == CMD_ROW) && (row_pos < {1'b0, rows_eff});

   // column sums go to the scan unit
   mcn_col_scan u_col_scan (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (req_take && (load_index_ff < cols_eff) && (req_data.command == CMD_COLUMN)),
      .wr_addr  (load_index_ff[COL_AW-1:0]),
      .wr_data  ((req_data.margin_value > 7'd63) ? 6'd63 : req_data.margin_value[5:0]),
      .scan_req (scan_req),
      .scan_rsp (scan_rsp)
   );

   assign scan_req.start = (state_ff == ST_SCAN_START);
   assign scan_req.row   = j_ff;
   assign scan_req.cols  = cols_eff;

   // row sum memory
   always_ff @(posedge clock) begin
      if (row_wr) begin
         row_mem[row_pos[ROW_AW-1:0]] <= req_data.margin_value;
      end
      row_q_ff <= row_mem[j_ff];
   end

   // stack compare: pop while top key does not exceed the new key
   assign top_key = $signed({2'b00, top_ff.ex}) - $signed({9'd0, top_ff.row});
   assign new_key = $signed({2'b00, new_ff.ex}) - $signed({9'd0, new_ff.row});
   assign do_pop  = (depth_ff != '0) && (top_key <= new_key);
   assign node_wr = (state_ff == ST_POP) && !do_pop;
   assign ex      = sum_r_ff - sum_c_ff;

   // node stack memory
   always_ff @(posedge clock) begin
      if (node_wr) begin
         node_mem[depth_ff[ROW_AW-1:0]] <= new_ff;
      end
      node_q_ff <= node_mem[node_raddr_ff];
   end

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_LOAD;
         row_count_ff    <= 6'(MAX_ROWS);
         column_count_ff <= 7'(MAX_COLS);
         load_index_ff   <= '0;
         rsp_valid_ff    <= 1'b0;
         depth_ff        <= '0;
      end else begin
         if (csr_write_en) begin
            if (csr_index == CSR_ROW_COUNT) begin
               row_count_ff <= csr_wdata[5:0];
            end else if (csr_index == CSR_COLUMN_COUNT) begin
               column_count_ff <= csr_wdata;
            end
            load_index_ff <= '0;
         end
         case (state_ff)
            ST_LOAD: begin
               if (req_take && !csr_write_en) begin
                  if (load_index_ff < cols_eff) begin
                     if (req_data.command == CMD_COLUMN) begin
                        load_index_ff <= load_index_ff + 7'd1;
                     end
                  end else if (req_data.command == CMD_ROW) begin
                     if (row_pos >= {1'b0, rows_eff}) begin
                        load_index_ff <= '0;
                     end else if (row_pos + 7'd1 == {1'b0, rows_eff}) begin
                        load_index_ff <= '0;
                        j_ff          <= '0;
                        sum_r_ff      <= '0;
                        sum_c_ff      <= '0;
                        first_any_ff  <= 1'b0;
                        depth_ff      <= '0;
                        state_ff      <= ST_SCAN_START;
                     end else begin
                        load_index_ff <= load_index_ff + 7'd1;
                     end
                  end
               end
            end
            ST_SCAN_START: begin
               state_ff <= ST_SCAN_WAIT;
            end
            ST_SCAN_WAIT: begin
               if (scan_rsp.done) begin
                  sum_r_ff <= sum_r_ff + {5'd0, row_q_ff};
                  sum_c_ff <= sum_c_ff + {5'd0, scan_rsp.count};
                  state_ff <= ST_EVAL;
               end
            end
            ST_EVAL: begin
               // first pruning: strict rise over the last kept excess
               if (sum_r_ff > sum_c_ff && (!first_any_ff || ex > last_ex_ff)) begin
                  first_any_ff <= 1'b1;
                  last_ex_ff   <= ex;
                  new_ff.row   <= j_ff;
                  new_ff.ex    <= ex;
                  state_ff     <= ST_POP;
               end else begin
                  state_ff <= ST_NEXT;
               end
            end
            ST_POP: begin
               if (do_pop) begin
                  depth_ff <= depth_ff - 6'd1;
                  if (depth_ff > 6'd1) begin
                     node_raddr_ff <= ROW_AW'(depth_ff - 6'd2);
                     state_ff      <= ST_POP_RD;
                  end
               end else begin
                  top_ff   <= new_ff;
                  depth_ff <= depth_ff + 6'd1;
                  state_ff <= ST_NEXT;
               end
            end
            ST_POP_RD: begin
               state_ff <= ST_POP_LD;
            end
            ST_POP_LD: begin
               top_ff   <= node_q_ff;
               state_ff <= ST_POP;
            end
            ST_NEXT: begin
               if ({1'b0, j_ff} + 6'd1 == rows_eff) begin
                  if (depth_ff == '0) begin
                     rsp_ff.node_row    <= '0;
                     rsp_ff.node_excess <= '0;
                     rsp_ff.no_nodes    <= 1'b1;
                     rsp_ff.last_node   <= 1'b1;
                     rsp_valid_ff       <= 1'b1;
                     state_ff           <= ST_OUT_HOLD;
                  end else begin
                     k_ff          <= '0;
                     node_raddr_ff <= '0;
                     state_ff      <= ST_OUT_RD;
                  end
               end else begin
                  j_ff     <= j_ff + 5'd1;
                  state_ff <= ST_SCAN_START;
               end
            end
            ST_OUT_RD: begin
               state_ff <= ST_OUT_LD;
            end
            ST_OUT_LD: begin
               rsp_ff.node_row    <= node_q_ff.row;
               rsp_ff.node_excess <= node_q_ff.ex;
               rsp_ff.no_nodes    <= 1'b0;
               rsp_ff.last_node   <= ({1'b0, k_ff} + 6'd1 == depth_ff);
               rsp_valid_ff       <= 1'b1;
               state_ff           <= ST_OUT_HOLD;
            end
            ST_OUT_HOLD: begin
               if (!rsp_stall) begin
                  rsp_valid_ff <= 1'b0;
                  if (rsp_ff.last_node) begin
                     state_ff <= ST_LOAD;
                  end else begin
                     k_ff          <= k_ff + 5'd1;
                     node_raddr_ff <= ROW_AW'(k_ff + 5'd1);
                     state_ff      <= ST_OUT_RD;
                  end
               end
            end
            default: begin
               state_ff <= ST_LOAD;
            end
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

FILE: src/mcn_col_scan.sv
// mcn_col_scan: column sum memory and adjusted conjugate counter
// depends on mcn_pkg
`timescale 1ns / 1ps

module mcn_col_scan
   import mcn_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              wr_en,
   input  logic [COL_AW-1:0] wr_addr,
   input  logic [5:0]        wr_data,
   input  mcn_scan_req_type  scan_req,
   output mcn_scan_rsp_type  scan_rsp
);

   logic [5:0] col_mem [MAX_COLS];
   logic [5:0] col_q_ff;
   logic [5:0] col0_ff;
   logic [6:0] idx_ff;
   logic       run_ff;
   logic       qv_ff;
   logic       qlast_ff;
   logic [5:0] thr_ff;
   logic [6:0] cnt_ff;
   logic       done_ff;
   logic [6:0] result_ff;
   logic [6:0] cnt_in;
   logic [6:0] idx_next;

   // column memory, one write and one read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         col_mem[wr_addr] <= wr_data;
      end
      col_q_ff <= col_mem[idx_ff[COL_AW-1:0]];
   end

   // first column sum kept aside for the adjustment
   always_ff @(posedge clock) begin
      if (wr_en && wr_addr == '0) begin
         col0_ff <= wr_data;
      end
   end

   assign idx_next = idx_ff + 7'd1;
   assign cnt_in   = cnt_ff + {6'd0, (col_q_ff >= thr_ff)};

   // scan over the columns, one per cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff   <= 1'b0;
         qv_ff    <= 1'b0;
         qlast_ff <= 1'b0;
         done_ff  <= 1'b0;
      end else begin
         done_ff  <= 1'b0;
         qv_ff    <= run_ff;
         qlast_ff <= run_ff && (idx_next == scan_req.cols);
         if (scan_req.start) begin
            run_ff <= 1'b1;
            idx_ff <= '0;
            cnt_ff <= '0;
            thr_ff <= {1'b0, scan_req.row} + 6'd1;
         end else begin
            if (run_ff) begin
               idx_ff <= idx_next;
               if (idx_next == scan_req.cols) begin
                  run_ff <= 1'b0;
               end
            end
            if (qv_ff) begin
               cnt_ff <= cnt_in;
               if (qlast_ff) begin
                  done_ff   <= 1'b1;
                  result_ff <= cnt_in - {6'd0, (thr_ff <= col0_ff)};
               end
            end
         end
      end
   end

   assign scan_rsp.done  = done_ff;
   assign scan_rsp.count = result_ff;

endmodule
